// File: design/ifmt_pkg.sv
// Shared types, constants and helpers of the integer to ASCII formatter.
package ifmt_pkg;

  // Width of the printed word; the input value is cut or zero-extended to it.
  localparam int WordBits  = 32;
  localparam int DecDigits = (WordBits * 30103) / 100000 + 1;
  localparam int HexDigits = (WordBits + 3) / 4;
  localparam int NumDigits = (DecDigits > HexDigits) ? DecDigits : HexDigits;
  localparam int NibBits   = NumDigits * 4;
  localparam int CntBits   = $clog2(WordBits);
  localparam int RemBits   = $clog2(NumDigits);

  // Format command codes.
  localparam logic [2:0] CmdSdec = 3'd0;
  localparam logic [2:0] CmdUdec = 3'd1;
  localparam logic [2:0] CmdLhex = 3'd2;
  localparam logic [2:0] CmdUhex = 3'd3;
  localparam logic [2:0] CmdPtr  = 3'd4;

  // Character codes.
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChX     = 7'h78;
  localparam logic [6:0] ChUpA   = 7'h41;
  localparam logic [6:0] ChLoA   = 7'h61;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StPfx,
    StDig
  } state_e;

  // Commands from the sequencer to the digit store.
  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift_nib;
  } ctl_t;

  // ASCII code of one digit nibble.
  function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [6:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      digit_char = ChZero + ext;
    end else begin
      digit_char = (upper ? ChUpA : ChLoA) + ext - 7'd10;
    end
  endfunction

endpackage

// File: design/ifmt_conv.sv
// Digit store: bit-serial binary to BCD conversion, hex load and nibble shift-out.
module ifmt_conv (
  input  logic                            clk_i,
  input  ifmt_pkg::ctl_t                  ctl_i,
  input  logic [ifmt_pkg::WordBits-1:0]   mag_i,
  output logic [3:0]                      top_nib_o
);
  import ifmt_pkg::*;

  logic [WordBits-1:0] bin_q, bin_d;
  logic [NibBits-1:0]  nib_q, nib_d;
  logic [NibBits-1:0]  adj;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i*4 +: 4] = (nib_q[i*4 +: 4] >= 4'd5) ? nib_q[i*4 +: 4] + 4'd3 : nib_q[i*4 +: 4];
    end
  end

  // Next value of the binary shifter and the digit store.
  always_comb begin
    bin_d = bin_q;
    nib_d = nib_q;
    if (ctl_i.load_dec) begin
      bin_d = mag_i;
      nib_d = '0;
    end else if (ctl_i.load_hex) begin
      nib_d = NibBits'(mag_i);
    end else if (ctl_i.dabble) begin
      bin_d = bin_q << 1;
      nib_d = {adj[NibBits-2:0], bin_q[WordBits-1]};
    end else if (ctl_i.shift_nib) begin
      nib_d = nib_q << 4;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    nib_q <= nib_d;
  end

  assign top_nib_o = nib_q[NibBits-1 -: 4];

endmodule

// File: design/ifmt_out.sv
// Output register that holds one character until the sink takes it.
module ifmt_out (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [6:0] char_i,
  input  logic       last_i,
  output logic       free_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [6:0] char_code, [7] zero
  output logic       m_axis_tlast_o   // last_char
);
  logic       valid_q, valid_d;
  logic [6:0] char_q;
  logic       last_q;

  // The slot is free when empty or when its character leaves this cycle.
  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = push_i || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      char_q <= char_i;
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {1'b0, char_q};
  assign m_axis_tlast_o  = last_q;

endmodule

// File: design/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: sequencer, digit store, output register.
//
//   Port group   Direction  tdata          tuser  tlast
//   s_axis       in         value (32)     cmd    -
//   m_axis       out        char_code (7)  -      last_char
//
// Decimal formats pass through an accept state, one double-dabble step per word bit, a
// skip of leading zero digits and a state to leave it, then one character per cycle while
// the sink keeps up. Hex formats skip the conversion loop; pointer form adds 0x.
// One request is worked at a time; the next is taken once the last character is in the
// output register. A stalled sink holds the sequencer while it emits characters; an
// unused format code is dropped in its accept cycle. Reset clears the sequencer and the
// output valid flag.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast_o    // last_char
);
  import ifmt_pkg::*;

  state_e              state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [1:0]          pfx_q, pfx_d;
  logic                ptr_q, ptr_d;
  logic                upper_q, upper_d;

  ctl_t                ctl;
  logic [WordBits-1:0] word, mag;
  logic                neg;
  logic [3:0]          top_nib;
  logic                free, push, last;
  logic [6:0]          chr;

  // Magnitude of the incoming word; negative only in signed decimal.
  assign word = WordBits'(s_axis_tdata_i);
  assign neg  = (s_axis_tuser_i == CmdSdec) && word[WordBits-1];
  assign mag  = neg ? (~word + 1'b1) : word;

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      rem_q   <= '0;
      pfx_q   <= '0;
      ptr_q   <= 1'b0;
      upper_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      pfx_q   <= pfx_d;
      ptr_q   <= ptr_d;
      upper_q <= upper_d;
    end
  end

  // Next state and character selection.
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    rem_d           = rem_q;
    pfx_d           = pfx_q;
    ptr_d           = ptr_q;
    upper_d         = upper_q;
    ctl             = '0;
    push            = 1'b0;
    chr             = ChZero;
    last            = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && (s_axis_tuser_i <= CmdPtr)) begin
          upper_d = (s_axis_tuser_i == CmdUhex);
          ptr_d   = (s_axis_tuser_i == CmdPtr);
          pfx_d   = (s_axis_tuser_i == CmdPtr) ? 2'd2 : (neg ? 2'd1 : 2'd0);
          if (s_axis_tuser_i == CmdSdec || s_axis_tuser_i == CmdUdec) begin
            ctl.load_dec = 1'b1;
            cnt_d        = CntBits'(WordBits - 1);
            state_d      = StConv;
          end else begin
            ctl.load_hex = 1'b1;
            rem_d        = RemBits'(NumDigits - 1);
            state_d      = StSkip;
          end
        end
      end
      StConv: begin
        ctl.dabble = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = RemBits'(NumDigits - 1);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zero digits, keeping at least one.
        if (top_nib == 4'd0 && rem_q != '0) begin
          ctl.shift_nib = 1'b1;
          rem_d         = rem_q - 1'b1;
        end else begin
          state_d = (pfx_q != 2'd0) ? StPfx : StDig;
        end
      end
      StPfx: begin
        if (free) begin
          push  = 1'b1;
          chr   = ptr_q ? ((pfx_q == 2'd2) ? ChZero : ChX) : ChMinus;
          pfx_d = pfx_q - 1'b1;
          if (pfx_q == 2'd1) begin
            state_d = StDig;
          end
        end
      end
      StDig: begin
        if (free) begin
          push          = 1'b1;
          chr           = digit_char(top_nib, upper_q);
          last          = (rem_q == '0);
          ctl.shift_nib = 1'b1;
          rem_d         = rem_q - 1'b1;
          if (rem_q == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  ifmt_conv u_conv (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .mag_i     (mag),
    .top_nib_o (top_nib)
  );

  ifmt_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .char_i          (chr),
    .last_i          (last),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: design/ifmt_checker.sv
// Port-level checks of the integer to ASCII formatter and their binding.
module ifmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import ifmt_pkg::*;

  // A held character does not change while the sink stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output request changed while stalled");

  // No character is pending right after reset.
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid after reset");

  // Every emitted code is a printable character of the formats.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7] == 1'b0) && (m_axis_tdata_o >= 8'h2d)
      && (m_axis_tdata_o <= 8'h7a))
    else $error("non-printable character code");

  // A valid format request keeps the input closed in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i <= CmdPtr) |=> !s_axis_tready_o)
    else $error("input open while a request is in work");

endmodule

bind integer_to_ascii_formatter ifmt_checker u_ifmt_checker (.*);

// File: bench/tb_integer_to_ascii_formatter.sv
// Testbench for the integer to ASCII formatter: directed and random requests checked per character.
module tb_integer_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import ifmt_pkg::*;

  // Format codes the block does not use; a request with one of them yields no characters.
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam int RandomRequests = 190;
  localparam int CalmRequests   = 40;
  localparam int DrainCycles    = 60;

  typedef struct {
    logic [6:0] code;
    logic       last;
  } char_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    bit          typed;
    string       text;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic [2:0]  s_axis_tuser_i;   // [2:0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [6:0] char_code, [7] zero
  logic        m_axis_tlast_o;   // last_char

  char_t pending_chars[$];
  int    fail_count = 0;
  bit    idle_on    = 1'b1;

  // Short directed set: extremes of every format, zero, the most negative word and unused codes.
  stim_row_t directed_rows[21] = '{
    '{CmdSdec,   32'h0000_0000, 1'b1, "0"},
    '{CmdSdec,   32'h8000_0000, 1'b1, "-2147483648"},
    '{CmdSdec,   32'h7FFF_FFFF, 1'b1, "2147483647"},
    '{CmdSdec,   32'hFFFF_FFFF, 1'b1, "-1"},
    '{CmdSdec,   32'h8000_0001, 1'b0, ""},
    '{CmdUdec,   32'hFFFF_FFFF, 1'b1, "4294967295"},
    '{CmdUdec,   32'h0000_0000, 1'b1, "0"},
    '{CmdUdec,   32'h8000_0000, 1'b0, ""},
    '{CmdUdec,   32'h0000_000A, 1'b0, ""},
    '{CmdLhex,   32'hFFFF_FFFF, 1'b1, "ffffffff"},
    '{CmdLhex,   32'h0000_0000, 1'b1, "0"},
    '{CmdLhex,   32'hABCD_EF09, 1'b0, ""},
    '{CmdUhex,   32'hFFFF_FFFF, 1'b1, "FFFFFFFF"},
    '{CmdUhex,   32'h0000_0000, 1'b1, "0"},
    '{CmdUhex,   32'h0000_00A5, 1'b0, ""},
    '{CmdPtr,    32'h0000_0000, 1'b1, "0x0"},
    '{CmdPtr,    32'hFFFF_FFFF, 1'b1, "0xffffffff"},
    '{CmdPtr,    32'h00C0_FFEE, 1'b0, ""},
    '{CmdSpare5, 32'h1234_5678, 1'b1, ""},
    '{CmdSpare6, 32'hFFFF_FFFF, 1'b1, ""},
    '{CmdSpare7, 32'h0000_0000, 1'b1, ""}
  };

  integer_to_ascii_formatter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Queue the characters of a literal text, flagging the final one.
  task automatic queue_text(input string text);
    char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.code = 7'(text[i]);
      ch.last = (i == text.len() - 1);
      pending_chars.push_back(ch);
    end
  endtask

  // Work out the text of one request and queue its characters, most significant first.
  task automatic render_word(input logic [2:0] cmd, input logic [31:0] value);
    logic [31:0] mag;
    logic [31:0] digit;
    logic [6:0]  text[16];
    logic [6:0]  digs[12];
    int          base;
    bit          upper;
    int          len;
    int          ndig;
    char_t       ch;
    mag   = value;
    base  = 16;
    upper = 1'b0;
    len   = 0;
    ndig  = 0;
    case (cmd)
      CmdSdec: begin
        base = 10;
        if (value[31]) begin
          text[len] = ChMinus;
          len++;
          mag = ~value + 32'd1;
        end
      end
      CmdUdec: base = 10;
      CmdLhex: base = 16;
      CmdUhex: upper = 1'b1;
      CmdPtr: begin
        text[0] = ChZero;
        text[1] = ChX;
        len = 2;
      end
      default: return;
    endcase
    // Digits come out least significant first, so collect them and reverse.
    do begin
      digit = mag % base;
      if (digit < 10) begin
        digs[ndig] = ChZero + digit[6:0];
      end else begin
        digs[ndig] = (upper ? ChUpA : ChLoA) + digit[6:0] - 7'd10;
      end
      ndig++;
      mag = mag / base;
    end while (mag != 0);
    for (int i = ndig - 1; i >= 0; i--) begin
      text[len] = digs[i];
      len++;
    end
    for (int i = 0; i < len; i++) begin
      ch.code = text[i];
      ch.last = (i == len - 1);
      pending_chars.push_back(ch);
    end
  endtask

  // Offer one request, possibly after an idle burst, and queue its characters once taken.
  task automatic send_request(input logic [2:0] cmd, input logic [31:0] value,
                              input bit typed, input string text);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    s_axis_tuser_i  = cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (typed) begin
      queue_text(text);
    end else begin
      render_word(cmd, value);
    end
  endtask

  // Random word biased toward small values, runs of ones, single bits and small negatives.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: pick_value = $urandom_range(0, 1000);
      1: pick_value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
      2: pick_value = 32'd1 << $urandom_range(0, 31);
      3: pick_value = -$urandom_range(1, 1000);
      default: pick_value = $urandom;
    endcase
  endfunction

  // Sink side: random stall bursts while idling is allowed.
  initial begin
    m_axis_tready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Compare every accepted character against the oldest expectation.
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%02h with last_char %0b", m_axis_tdata_o[6:0],
               m_axis_tlast_o);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata_o[6:0] !== want.code) begin
          $error("char_code: expected 0x%02h, got 0x%02h", want.code, m_axis_tdata_o[6:0]);
          fail_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, m_axis_tlast_o);
          fail_count++;
        end
        if (m_axis_tdata_o[7] !== 1'b0) begin
          $error("tdata pad bit: expected 0, got %0b", m_axis_tdata_o[7]);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random requests, drain.
  initial begin
    logic [2:0] cmd;
    int         counted;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CmdSdec;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].text);
    end

    // Unused codes are ignored by the block and do not count toward the random total.
    counted = 0;
    while (counted < RandomRequests) begin
      if ($urandom_range(0, 19) == 0) begin
        cmd = 3'($urandom_range(CmdSpare5, CmdSpare7));
      end else begin
        cmd = 3'($urandom_range(CmdSdec, CmdPtr));
        counted++;
      end
      if (counted >= RandomRequests - CalmRequests) idle_on = 1'b0;
      send_request(cmd, pick_value(), 1'b0, "");
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
